/* hdl/csw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// csw_pkg
// Shared types and constants of the cubic spline support weight block.
// ---------------------------------------------------------------------------
package csw_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] REG_POINT_X  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_POINT_Y  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_POINT_Z  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_DILATION = 2'd3;

    localparam logic [15:0] DilationReset = 16'd8192;

    // iterative unit operations
    typedef enum logic [1:0] {
        t_OP_SQRT,
        t_OP_DIV
    } t_op;

    // iterative unit request
    typedef struct packed {
        t_op         op;
        logic [67:0] num;   // sqrt radicand, or dividend
        logic [47:0] den;   // divisor
        logic [6:0]  steps; // result bits to form
    } t_itu_req;

    typedef enum logic [4:0] {
        t_ST_IDLE,
        t_ST_SQ,
        t_ST_SQRT,
        t_ST_SQRT_W,
        t_ST_CHECK,
        t_ST_SDIV,
        t_ST_SDIV_W,
        t_ST_POLY1,
        t_ST_POLY2,
        t_ST_POLY3,
        t_ST_AX_C,
        t_ST_AX_CW,
        t_ST_AX_P,
        t_ST_AX_Q,
        t_ST_AX_QW,
        t_ST_AX_ST,
        t_ST_OUT
    } t_state;

endpackage
`default_nettype wire

/* hdl/csw_itu.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// csw_itu
// Shared iterative unit: restoring square root (two radicand bits a step)
// or restoring division (one quotient bit a step).
// ---------------------------------------------------------------------------
module csw_itu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire csw_pkg::t_itu_req i_req,
    output logic                   o_done,
    output logic [67:0]            o_result
);
    import csw_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done;
    t_op         r_op;
    logic [67:0] r_num;
    logic [47:0] r_den;
    logic [69:0] r_rem;
    logic [67:0] r_root;
    logic [6:0]  r_cnt;

    logic [69:0] w_rem_sh, w_trial, w_rem_n;
    logic [67:0] w_root_n, w_num_n;
    logic        w_ge;

    always_comb begin
        w_rem_n  = '0;
        w_root_n = '0;
        w_num_n  = '0;
        w_rem_sh = '0;
        w_trial  = '0;
        unique case (r_op)
            t_OP_SQRT: begin
                w_rem_sh = {r_rem[67:0], r_num[67:66]};
                w_trial  = {r_root, 2'b01};
                w_num_n  = {r_num[65:0], 2'b00};
            end
            default: begin
                w_rem_sh = {r_rem[68:0], r_num[67]};
                w_trial  = {22'd0, r_den};
                w_num_n  = {r_num[66:0], 1'b0};
            end
        endcase
        w_ge     = (w_rem_sh >= w_trial);
        w_rem_n  = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
        w_root_n = {r_root[66:0], w_ge};
    end

    always_comb begin
        n_busy = r_busy;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && (r_cnt == 7'd1)) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && !i_start && (r_cnt == 7'd1);
        end
    end

    // operand bits enter from bit 67; zeros follow past bit 0
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_req.op;
            r_den  <= i_req.den;
            r_cnt  <= i_req.steps;
            r_rem  <= '0;
            r_root <= '0;
            r_num  <= i_req.num;
        end else if (r_busy) begin
            r_rem  <= w_rem_n;
            r_root <= w_root_n;
            r_num  <= w_num_n;
            r_cnt  <= r_cnt - 7'd1;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_root;

endmodule
`default_nettype wire

/* hdl/cubic_spline_support_weights.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cubic_spline_support_weights
// Cubic spline weight and gradient of one node against the Gauss point.
// ---------------------------------------------------------------------------
// Sequence per node in support: squared distance, a 34-step root, a 76-step
//   normalize, then per axis a 63-step and a 46-step divide; on support
//   overflow the steps end after the root. A new node is taken only in idle;
//   one shared root/divide unit serves every step.
// Reset: synchronous, active low; point registers clear, dilation 2.0,
//   support count zero.
module cubic_spline_support_weights #(
    parameter int unsigned MAX_SUPPORT = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [csw_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire logic [csw_pkg::CfgDataW-1:0]    i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic signed [31:0]              i_node_x,
    input  wire logic signed [31:0]              i_node_y,
    input  wire logic signed [31:0]              i_node_z,
    input  wire logic [31:0]                     i_node_radius,
    input  wire logic [15:0]                     i_node_index,
    input  wire logic                            i_last_node,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [15:0]                          o_support_node,
    output logic [5:0]                           o_support_slot,
    output logic [30:0]                          o_weight,
    output logic signed [31:0]                   o_grad_x,
    output logic signed [31:0]                   o_grad_y,
    output logic signed [31:0]                   o_grad_z,
    output logic                                 o_overflow
);
    import csw_pkg::*;

    localparam int unsigned CntW = $clog2(MAX_SUPPORT + 1);

    // configuration
    logic signed [31:0] r_px, r_py, r_pz;
    logic [15:0]        r_dil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px  <= '0;
            r_py  <= '0;
            r_pz  <= '0;
            r_dil <= DilationReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POINT_X:  r_px  <= i_cfg_data;
                REG_POINT_Y:  r_py  <= i_cfg_data;
                REG_POINT_Z:  r_pz  <= i_cfg_data;
                REG_DILATION: r_dil <= i_cfg_data[15:0];
                default:      r_dil <= r_dil;
            endcase
        end
    end

    t_state r_st, n_st;

    // item registers
    logic signed [32:0] r_d [3];
    logic [31:0]        r_rad;
    logic [15:0]        r_idx;
    logic               r_last;
    logic [47:0]        r_a;
    logic [65:0]        r_sq;
    logic [1:0]         r_sq_i;
    logic [33:0]        r_r;
    logic [31:0]        r_s;
    logic [31:0]        r_s2;
    logic [31:0]        r_s3;
    logic signed [35:0] r_g;
    logic [1:0]         r_ax;
    logic [31:0]        r_c;
    logic [65:0]        r_p;
    logic [CntW-1:0]    r_cnt;

    // result being formed
    logic               r_ovalid;
    logic [15:0]        r_onode;
    logic [5:0]         r_oslot;
    logic [30:0]        r_ow;
    logic [31:0]        r_og [3];
    logic               r_oovf;

    // output beat register
    logic [15:0]        r_bnode;
    logic [5:0]         r_bslot;
    logic [30:0]        r_bw;
    logic [31:0]        r_bg [3];
    logic               r_bovf;
    logic               w_fire;

    // shared iterative unit
    logic        w_start, w_done;
    t_itu_req    w_req;
    logic [67:0] w_res;

    csw_itu u_itu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_req    (w_req),
        .o_done   (w_done),
        .o_result (w_res)
    );

    logic        w_accept;
    logic [32:0] w_mag;
    logic [65:0] w_sqterm;
    logic        w_inside, w_full;
    logic [45:0] w_num;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_st == t_ST_IDLE);
    assign w_fire   = (r_st == t_ST_OUT) && (!r_ovalid || i_ready);
    assign w_mag    = r_d[r_sq_i][32] ? 33'(-r_d[r_sq_i]) : 33'(r_d[r_sq_i]);
    assign w_sqterm = 66'(w_mag) * 66'(w_mag);
    assign w_num    = {r_r, 12'd0};
    assign w_inside = (r_sq != '0) && ({2'd0, w_num} <= r_a);
    assign w_full   = (32'(r_cnt) >= 32'(MAX_SUPPORT));

    // polynomial stage (one product per state)
    logic [63:0] w_prod;
    always_comb begin
        unique case (r_st)
            t_ST_POLY1: w_prod = 64'(r_s) * 64'(r_s);
            t_ST_POLY2: w_prod = 64'(r_s2) * 64'(r_s);
            default:    w_prod = 64'(r_s) * 64'(r_s);
        endcase
    end

    logic signed [35:0] w_wraw;
    logic signed [35:0] w_graw;
    logic               w_near;
    logic [63:0]        w_s3m;
    logic [33:0]        w_s3d;
    assign w_near = (r_s <= 32'h2000_0000);
    // floor(4 s3 / 3) as s3 + s3 / 3 by reciprocal
    assign w_s3m  = 64'(r_s3) * 64'hAAAA_AAAB;
    assign w_s3d  = 34'(r_s3) + 34'(w_s3m[63:33]);
    always_comb begin
        if (w_near) begin
            w_wraw = 36'sd715827883 - 36'(signed'({2'b0, r_s2, 2'b0}))
                   + 36'(signed'({2'b0, r_s3, 2'b0}));
            w_graw = -36'(signed'({1'b0, r_s, 3'b0}))
                   + 36'(signed'({2'b0, r_s2, 2'b0})) * 36'sd3;
        end else begin
            w_wraw = 36'sd1431655765 - 36'(signed'({2'b0, r_s, 2'b0}))
                   + 36'(signed'({2'b0, r_s2, 2'b0}))
                   - 36'(signed'({2'b0, w_s3d}));
            w_graw = -36'sh1_0000_0000 + 36'(signed'({1'b0, r_s, 3'b0}))
                   - 36'(signed'({2'b0, r_s2, 2'b0}));
        end
    end

    logic [30:0] w_wclamp;
    assign w_wclamp = w_wraw[35] ? 31'd0 :
                      (w_wraw > 36'sh4000_0000) ? 31'h4000_0000 : w_wraw[30:0];

    logic [35:0] w_gabs;
    logic [32:0] w_dabs;
    logic        w_neg;
    logic [67:0] w_q;
    logic [31:0] w_gout;
    assign w_gabs = r_g[35] ? 36'(-r_g) : 36'(r_g);
    assign w_dabs = r_d[r_ax][32] ? 33'(-r_d[r_ax]) : 33'(r_d[r_ax]);
    assign w_neg  = r_d[r_ax][32] != r_g[35];
    assign w_q    = w_res;
    always_comb begin
        if (w_neg) begin
            w_gout = (w_q >= 68'h8000_0000) ? 32'h8000_0000 : 32'(-w_q[31:0]);
        end else begin
            w_gout = (w_q > 68'h7FFF_FFFF) ? 32'h7FFF_FFFF : w_q[31:0];
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            t_ST_IDLE:   if (w_accept) n_st = t_ST_SQ;
            t_ST_SQ:     if (r_sq_i == 2'd2) n_st = t_ST_SQRT;
            t_ST_SQRT:   n_st = t_ST_SQRT_W;
            t_ST_SQRT_W: if (w_done) n_st = t_ST_CHECK;
            t_ST_CHECK: begin
                if (!w_inside) n_st = t_ST_IDLE;
                else if (w_full) n_st = t_ST_OUT;
                else n_st = t_ST_SDIV;
            end
            t_ST_SDIV:   n_st = t_ST_SDIV_W;
            t_ST_SDIV_W: if (w_done) n_st = t_ST_POLY1;
            t_ST_POLY1:  n_st = t_ST_POLY2;
            t_ST_POLY2:  n_st = t_ST_POLY3;
            t_ST_POLY3:  n_st = t_ST_AX_C;
            t_ST_AX_C:   n_st = t_ST_AX_CW;
            t_ST_AX_CW:  if (w_done) n_st = t_ST_AX_P;
            t_ST_AX_P:   n_st = t_ST_AX_Q;
            t_ST_AX_Q:   n_st = t_ST_AX_QW;
            t_ST_AX_QW:  if (w_done) n_st = t_ST_AX_ST;
            t_ST_AX_ST:  n_st = (r_ax == 2'd2) ? t_ST_OUT : t_ST_AX_C;
            t_ST_OUT:    n_st = w_fire ? t_ST_IDLE : t_ST_OUT;
            default:     n_st = t_ST_IDLE;
        endcase
    end

    // unit requests
    always_comb begin
        w_start = 1'b0;
        w_req   = '{op: t_OP_SQRT, num: '0, den: '0, steps: '0};
        unique case (r_st)
            t_ST_SQRT: begin
                w_start = 1'b1;
                w_req   = '{op: t_OP_SQRT, num: {2'd0, r_sq}, den: '0, steps: 7'd34};
            end
            t_ST_SDIV: begin
                w_start = 1'b1;
                w_req   = '{op: t_OP_DIV, num: {w_num, 22'd0}, den: r_a, steps: 7'd76};
            end
            t_ST_AX_C: begin
                w_start = 1'b1;
                w_req   = '{op: t_OP_DIV, num: {w_dabs, 35'd0},
                            den: {14'd0, r_r}, steps: 7'd63};
            end
            t_ST_AX_Q: begin
                w_start = 1'b1;
                w_req   = '{op: t_OP_DIV, num: {r_p[31:0], 36'd0},
                            den: r_a, steps: 7'd46};
            end
            default: w_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= t_ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_fire) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if ((r_st == t_ST_CHECK && !w_inside) || w_fire) begin
                if (r_last) begin
                    r_cnt <= '0;
                end else if (w_fire && !r_oovf) begin
                    r_cnt <= r_cnt + CntW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_bnode <= r_onode;
            r_bslot <= r_oslot;
            r_bw    <= r_ow;
            r_bg[0] <= r_og[0];
            r_bg[1] <= r_og[1];
            r_bg[2] <= r_og[2];
            r_bovf  <= r_oovf;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            t_ST_IDLE: begin
                r_d[0] <= 33'(i_node_x) - 33'(r_px);
                r_d[1] <= 33'(i_node_y) - 33'(r_py);
                r_d[2] <= 33'(i_node_z) - 33'(r_pz);
                r_rad  <= i_node_radius;
                r_idx  <= i_node_index;
                r_last <= i_last_node;
                r_sq   <= '0;
                r_sq_i <= '0;
            end
            t_ST_SQ: begin
                r_sq   <= r_sq + w_sqterm;
                r_sq_i <= r_sq_i + 2'd1;
                r_a    <= 48'(r_dil) * 48'(r_rad);
            end
            t_ST_SQRT_W: r_r <= w_res[33:0];
            t_ST_CHECK: begin
                r_ax   <= '0;
                r_oovf <= w_full;
                r_onode <= r_idx;
                r_oslot <= '0;
                r_ow    <= '0;
                r_og[0] <= '0;
                r_og[1] <= '0;
                r_og[2] <= '0;
            end
            t_ST_SDIV_W: r_s <= w_res[31:0];
            t_ST_POLY1:  r_s2 <= w_prod[61:30];
            t_ST_POLY2:  r_s3 <= w_prod[61:30];
            t_ST_POLY3: begin
                r_g     <= w_graw;
                r_ow    <= w_wclamp;
                r_oslot <= 6'(r_cnt);
            end
            t_ST_AX_CW:  r_c <= w_res[31:0];
            t_ST_AX_P:   r_p <= 66'((68'(w_gabs) * 68'(r_c)) >> 30);
            t_ST_AX_ST: begin
                r_og[r_ax] <= w_gout;
                r_ax       <= r_ax + 2'd1;
            end
            default: r_ax <= r_ax;
        endcase
    end

    assign o_valid        = r_ovalid;
    assign o_support_node = r_bnode;
    assign o_support_slot = r_bslot;
    assign o_weight       = r_bw;
    assign o_grad_x       = r_bg[0];
    assign o_grad_y       = r_bg[1];
    assign o_grad_z       = r_bg[2];
    assign o_overflow     = r_bovf;

endmodule
`default_nettype wire
